>>> src/olen_pkg.sv
// Package for the ordered list engine: operation codes, status codes,
// cell control and result types. No dependencies.
`default_nettype none

package olen_pkg;

	// Operation codes carried in the mode field
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} olen_status_t;

	// Commands broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp;      // compare entry against key, load match flag
		logic scan;     // shift match flags one cell toward the head
		logic append;   // write key into the cell at the tail position
		logic compact;  // cells at or after the hit take the right neighbor's entry
	} olen_cell_ctl_t;

	// One result item, status in the lowest bits
	typedef struct packed {
		logic [4:0]   count;
		logic [3:0]   pos;
		olen_status_t status;
	} olen_result_t;

endpackage

`default_nettype wire

>>> src/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer plus a chain of storage cells.
// Depends on olen_pkg, olen_ctrl and olen_cell.
//
//   channel  | dir | tdata bits (low first)                            | tuser
//   s_axis   | in  | [1:0] mode, [33:2] operand_value, [39:34] zero     | -
//   m_axis   | out | [1:0] status, [5:2] found_position,                | -
//            |     | [10:6] entry_count, [15:11] zero                   |
//
// One transaction at a time. Append, the unused mode and a delete or search on an
// empty list finish in the compare state; delete and search on a nonempty list
// also scan, the match flags walking one cell per cycle down the chain to the
// head cell, and then finish in the update state.
// Reset clears the fill count and control; entries need no clearing.
// A result waiting on m_axis does not block acceptance of the next transaction;
// the sequencer holds its finished result until the output register is free.
`default_nettype none

module ordered_list_engine import olen_pkg::*; #(
	parameter int LIST_DEPTH  = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // mode[1:0], operand_value[33:2], zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // status[1:0], found_position[5:2],
	                                        // entry_count[10:6], zero
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = $clog2(LIST_DEPTH);

	olen_cell_ctl_t         ctl;
	logic [VALUE_WIDTH-1:0] key;
	logic [CNT_W-1:0]       fill;
	logic [IDX_W-1:0]       hit;
	olen_result_t           res;
	logic [VALUE_WIDTH-1:0] entry [LIST_DEPTH+1];
	logic                   match [LIST_DEPTH+1];

	// Sequencer
	olen_ctrl #(
		.LIST_DEPTH  (LIST_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.CNT_W       (CNT_W),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_mode     (s_axis_tdata[1:0]),
		.s_operand  (s_axis_tdata[33:2]),
		.s_ready    (s_axis_tready),
		.head_match (match[0]),
		.ctl        (ctl),
		.key        (key),
		.fill       (fill),
		.hit        (hit),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_res      (res)
	);

	// Terminate the chain past the tail cell
	assign entry[LIST_DEPTH] = '0;
	assign match[LIST_DEPTH] = 1'b0;

	// Cell chain, position 0 is the head
	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		olen_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.CNT_W       (CNT_W),
			.IDX_W       (IDX_W),
			.IDX         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key       (key),
			.fill      (fill),
			.hit       (hit),
			.nxt_entry (entry[i+1]),
			.nxt_match (match[i+1]),
			.entry     (entry[i]),
			.match     (match[i])
		);
	end

	assign m_axis_tdata = {5'b0, res};

endmodule

`default_nettype wire

>>> src/olen_cell.sv
// One storage cell of the list chain: holds one entry and one match flag.
// Depends on olen_pkg for the command struct.
`default_nettype none

module olen_cell import olen_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int CNT_W       = 5,
	parameter int IDX_W       = 4,
	parameter int IDX         = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire olen_cell_ctl_t         ctl,
	input  wire logic [VALUE_WIDTH-1:0] key,
	input  wire logic [CNT_W-1:0]       fill,
	input  wire logic [IDX_W-1:0]       hit,
	input  wire logic [VALUE_WIDTH-1:0] nxt_entry,
	input  wire logic                   nxt_match,
	output logic [VALUE_WIDTH-1:0]      entry,
	output logic                        match
);

	localparam logic [CNT_W-1:0] POS_C = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] POS_I = IDX_W'(IDX);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   match_q;

	// Store: append at the tail, or close the gap after a delete
	always_ff @(posedge clk) begin
		if (ctl.append && (fill == POS_C)) begin
			entry_q <= key;
		end else if (ctl.compact && (POS_I >= hit)) begin
			entry_q <= nxt_entry;
		end
	end

	// Match flag: load from compare, then shift toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= (POS_C < fill) && (entry_q == key);
		end else if (ctl.scan) begin
			match_q <= nxt_match;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

`default_nettype wire

>>> src/olen_ctrl.sv
// Sequencer of the ordered list engine: input capture, fill count, scan of the
// match chain, result register. Depends on olen_pkg.
`default_nettype none

module olen_ctrl import olen_pkg::*; #(
	parameter int LIST_DEPTH  = 16,
	parameter int VALUE_WIDTH = 32,
	parameter int CNT_W       = $clog2(LIST_DEPTH + 1),
	parameter int IDX_W       = $clog2(LIST_DEPTH)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_valid,
	input  wire logic [1:0]             s_mode,
	input  wire logic [31:0]            s_operand,
	output logic                        s_ready,
	input  wire logic                   head_match,
	output olen_cell_ctl_t              ctl,
	output logic [VALUE_WIDTH-1:0]      key,
	output logic [CNT_W-1:0]            fill,
	output logic [IDX_W-1:0]            hit,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output olen_result_t                m_res
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMP  = 5'b00010,
		S_SCAN = 5'b00100,
		S_UPD  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                 state_q, state_d;
	logic [1:0]             mode_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]       fill_q;
	logic [IDX_W-1:0]       k_q;
	logic [IDX_W-1:0]       hit_q;
	logic                   found_q;
	olen_result_t           res_q;
	olen_result_t           fin_res;
	logic                   fin;
	logic                   out_v_q;
	olen_result_t           out_res_q;
	logic                   push;
	logic [63:0]            op_ext;

	// Sign-extend the operand, keep the stored width
	assign op_ext = {{32{s_operand[31]}}, s_operand};

	// Sequence one transaction
	always_comb begin
		logic [CNT_W+4:0] cnt_x;
		logic [IDX_W+3:0] hit_x;
		logic [CNT_W-1:0] cnt_new;

		state_d = state_q;
		ctl     = '0;
		fin     = 1'b0;
		cnt_new = fill_q;
		fin_res = '0;
		fin_res.status = ST_DONE;
		hit_x   = {4'b0, hit_q};
		s_ready = 1'b0;

		case (state_q)
			S_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctl.cmp = 1'b1;
				case (mode_q)
					MODE_APPEND: begin
						fin = 1'b1;
						if (fill_q == DEPTH_C) begin
							fin_res.status = ST_FULL;
						end else begin
							ctl.append = 1'b1;
							cnt_new    = fill_q + ONE_C;
						end
					end
					MODE_DELETE, MODE_SEARCH: begin
						if (fill_q == '0) begin
							fin            = 1'b1;
							fin_res.status = ST_EMPTY;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (CNT_W'(k_q) == fill_q - ONE_C) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				fin = 1'b1;
				if (!found_q) begin
					fin_res.status = ST_NOT_FOUND;
				end else if (mode_q == MODE_DELETE) begin
					ctl.compact = 1'b1;
					cnt_new     = fill_q - ONE_C;
				end else begin
					fin_res.pos = hit_x[3:0];
				end
			end
			S_DONE: begin
				if (!out_v_q || m_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		cnt_x         = {5'b0, cnt_new};
		fin_res.count = cnt_x[4:0];
		if (fin) begin
			state_d = S_DONE;
		end
	end

	assign push = (state_q == S_DONE) && (!out_v_q || m_ready);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			found_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.append) begin
				fill_q <= fill_q + ONE_C;
			end else if (ctl.compact) begin
				fill_q <= fill_q - ONE_C;
			end
			if (ctl.cmp) begin
				found_q <= 1'b0;
			end else if (ctl.scan && head_match) begin
				found_q <= 1'b1;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers: operands, scan position, hit, results
	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			mode_q <= s_mode;
			key_q  <= op_ext[VALUE_WIDTH-1:0];
		end
		if (ctl.cmp) begin
			k_q <= '0;
		end else if (ctl.scan) begin
			k_q <= k_q + IDX_W'(1);
			// delete keeps the last match, search keeps the first
			if (head_match && ((mode_q == MODE_DELETE) || !found_q)) begin
				hit_q <= k_q;
			end
		end
		if (fin) begin
			res_q <= fin_res;
		end
		if (push) begin
			out_res_q <= res_q;
		end
	end

	assign key     = key_q;
	assign fill    = fill_q;
	assign hit     = hit_q;
	assign m_valid = out_v_q;
	assign m_res   = out_res_q;

endmodule

`default_nettype wire

>>> src/olen_chk.sv
// Port-level checker for the ordered list engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module olen_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [39:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	localparam logic [1:0] ST_DONE_C  = 2'd0;
	localparam logic [1:0] ST_EMPTY_C = 2'd3;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Only one transaction in flight on the input side
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// Any status other than done carries no position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != ST_DONE_C) |-> m_axis_tdata[5:2] == 4'd0)
		else $error("position set on a failed operation");

	// An empty report shows an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ST_EMPTY_C) |-> m_axis_tdata[10:6] == 5'd0)
		else $error("empty status with nonzero count");

	// Padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0)
		else $error("padding bits set");

	// Reference the unused input padding so the checker sees the whole port
	logic unused_in;
	assign unused_in = ^s_axis_tdata;

endmodule

bind ordered_list_engine olen_chk u_olen_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
